// ===== sv/qbez_pkg.sv =====
// ----------------------------------------------------------------------------
// qbez_pkg
// Shared types and constants for the quadratic Bezier point generator.
// ----------------------------------------------------------------------------
package qbez_pkg;

	localparam int COORD_BITS = 16;
	localparam int SEG_BITS   = 6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] ctrl_x;
		logic signed [COORD_BITS-1:0] ctrl_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [SEG_BITS-1:0]          segments;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         last_point;
	} out_item_t;

endpackage

// ===== sv/quadratic_bezier_point_generator_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_point_generator_unit
// Emits the n+1 points of a quadratic Bezier curve for each request.
// ----------------------------------------------------------------------------
// A request of n segments yields n+1 result points, one per cycle when the
// output is not stalled. The request is registered and the point sequencer
// then issues its points in order of step k; the next request is taken in
// the cycle after the sequencer issues its last point, so a new request is
// not taken while one is still being issued. Each point runs through a
// weight stage, a multiply stage, a sum stage and a bit-per-stage divider,
// and a downstream stall freezes the pipe as a whole. A zero count acts as
// one; a count above MAX_SEGMENTS saturates.
module quadratic_bezier_point_generator_unit #(
	parameter int MAX_SEGMENTS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qbez_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qbez_pkg::out_item_t  out_data
);

	localparam int COORD_BITS = qbez_pkg::COORD_BITS;
	localparam int SB    = qbez_pkg::SEG_BITS;
	localparam int WB    = 2 * SB + 1;           // weight bits (each weight up to n^2)
	localparam int PB    = COORD_BITS + WB + 1;  // signed product bits
	localparam int NB    = PB + 3;               // 2*num + den
	localparam int DB    = 2 * SB + 2;           // 2*n^2

	// hold the request and step k
	logic signed [COORD_BITS-1:0] c_q [6];
	logic [SB-1:0] n_q, k_q;
	logic          busy_q;
	logic          en;
	logic          issue;
	logic [SB-1:0] n_in;

	assign in_ready = !busy_q;
	assign issue    = busy_q && en;

	always_comb begin
		n_in = in_data.segments;
		if (n_in == '0)
			n_in = SB'(1);
		if (n_in > SB'(MAX_SEGMENTS))
			n_in = SB'(MAX_SEGMENTS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			n_q    <= n_in;
		end else if (issue) begin
			if (k_q == n_q)
				busy_q <= 1'b0;
			k_q <= k_q + SB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_q[0] <= COORD_BITS'(in_data.start_x);
			c_q[1] <= COORD_BITS'(in_data.start_y);
			c_q[2] <= COORD_BITS'(in_data.ctrl_x);
			c_q[3] <= COORD_BITS'(in_data.ctrl_y);
			c_q[4] <= COORD_BITS'(in_data.end_x);
			c_q[5] <= COORD_BITS'(in_data.end_y);
		end
	end

	// stage 1: weights
	logic          v_s1, last_s1;
	logic [WB-1:0] w0_s1, w1_s1, w2_s1;
	logic [DB-1:0] d_s1;
	logic signed [COORD_BITS-1:0] c_s1 [6];
	logic [SB-1:0] a_w;
	assign a_w = n_q - k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= issue;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w0_s1   <= WB'(a_w) * WB'(a_w);
			w1_s1   <= (WB'(k_q) * WB'(a_w)) << 1;
			w2_s1   <= WB'(k_q) * WB'(k_q);
			d_s1    <= (DB'(n_q) * DB'(n_q)) << 1;
			last_s1 <= (k_q == n_q);
			for (int i = 0; i < 6; i++)
				c_s1[i] <= c_q[i];
		end
	end

	// stage 2: products
	logic          v_s2, last_s2;
	logic signed [PB-1:0] p_s2 [6];
	logic [DB-1:0] d_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				p_s2[j]   <= PB'(c_s1[j])   * PB'($signed({1'b0, w0_s1}));
				p_s2[j+2] <= PB'(c_s1[j+2]) * PB'($signed({1'b0, w1_s1}));
				p_s2[j+4] <= PB'(c_s1[j+4]) * PB'($signed({1'b0, w2_s1}));
			end
			d_s2    <= d_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: numerators 2*num + den
	logic          v_s3, last_s3;
	logic signed [NB-1:0] nx_s3, ny_s3;
	logic [DB-1:0] d_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= ((NB'(p_s2[0]) + NB'(p_s2[2]) + NB'(p_s2[4])) <<< 1)
				+ $signed(NB'(d_s2 >> 1));
			ny_s3 <= ((NB'(p_s2[1]) + NB'(p_s2[3]) + NB'(p_s2[5])) <<< 1)
				+ $signed(NB'(d_s2 >> 1));
			d_s3    <= d_s2;
			last_s3 <= last_s2;
		end
	end

	// divide both coordinates by 2*n^2
	logic dvx, dvy, lx, ly;
	logic signed [COORD_BITS-1:0] qx, qy;
	qbez_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(COORD_BITS), .TAG_BITS(1)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(nx_s3), .den(d_s3), .tag_in(last_s3),
		.out_valid(dvx), .quot(qx), .tag_out(lx)
	);
	qbez_div #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(COORD_BITS), .TAG_BITS(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(ny_s3), .den(d_s3), .tag_in(last_s3),
		.out_valid(dvy), .quot(qy), .tag_out(ly)
	);

	// advance the whole pipe unless the tail is stalled
	assign en        = !(dvx && !out_ready);
	assign out_valid = dvx;
	always_comb begin
		out_data            = '0;
		out_data.point_x    = qx;
		out_data.point_y    = qy;
		out_data.last_point = lx & dvy & ly;
	end

endmodule

// ===== sv/qbez_div.sv =====
// ----------------------------------------------------------------------------
// qbez_div
// Pipelined restoring divider: floor of a signed numerator by a positive
// denominator, one quotient bit per stage. Carries a tag alongside.
// ----------------------------------------------------------------------------
module qbez_div #(
	parameter int NUM_BITS = 30,
	parameter int DEN_BITS = 13,
	parameter int Q_BITS   = 16,
	parameter int TAG_BITS = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0]        den,
	input  logic [TAG_BITS-1:0]        tag_in,
	output logic                       out_valid,
	output logic signed [Q_BITS-1:0]   quot,
	output logic [TAG_BITS-1:0]        tag_out
);

	localparam int MAG_BITS = NUM_BITS;
	localparam int STAGES   = MAG_BITS;

	// per-stage registers: remainder, magnitude shifting out, sign, den, tag, valid
	logic [DEN_BITS:0]   rem_s   [STAGES+1];
	logic [MAG_BITS-1:0] mag_s   [STAGES+1];
	logic                neg_s   [STAGES+1];
	logic [DEN_BITS-1:0] den_s   [STAGES+1];
	logic [TAG_BITS-1:0] tag_s   [STAGES+1];
	logic                vld_s   [STAGES+1];

	// Negative numerators: floor(-m/d) = -((m + d - 1) / d); fold d-1 in.
	logic [MAG_BITS-1:0] mag_in;
	always_comb begin
		if (num < 0)
			mag_in = MAG_BITS'(-num) + MAG_BITS'(den) - MAG_BITS'(1);
		else
			mag_in = MAG_BITS'(num);
	end

	assign rem_s[0] = '0;
	assign mag_s[0] = mag_in;
	assign neg_s[0] = num[NUM_BITS-1];
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;
	assign vld_s[0] = in_valid;

	// one quotient bit per stage, quotient bits shift into mag low end
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic [DEN_BITS:0]   trial;
		logic [DEN_BITS+1:0] diff;
		assign trial = {rem_s[i][DEN_BITS-1:0], mag_s[i][MAG_BITS-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DEN_BITS+1]) begin
					rem_s[i+1] <= diff[DEN_BITS:0];
					mag_s[i+1] <= {mag_s[i][MAG_BITS-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= trial;
					mag_s[i+1] <= {mag_s[i][MAG_BITS-2:0], 1'b0};
				end
				neg_s[i+1] <= neg_s[i];
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign tag_out   = tag_s[STAGES];
	assign quot      = neg_s[STAGES] ? Q_BITS'(-mag_s[STAGES]) : Q_BITS'(mag_s[STAGES]);

endmodule

// ===== tb/tb_quadratic_bezier_point_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_bezier_point_generator_unit
// Self-checking bench: drives curve requests with random gaps, predicts each
// rounded curve point with exact integer math, and compares every result.
// ----------------------------------------------------------------------------
module tb_quadratic_bezier_point_generator_unit;

	localparam int LATENCY = 2 * 16 + 16 + 8;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	qbez_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	qbez_pkg::out_item_t out_data;

	qbez_pkg::out_item_t expected_points[$];
	int fail_count;
	int request_count;
	int point_count;
	int idle_cycles;
	bit hold_output;
	bit no_gaps;

	quadratic_bezier_point_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Round one coordinate to nearest, halves toward plus infinity
	function automatic logic signed [15:0] curve_coord(longint p0, longint p1, longint p2,
			longint n, longint k);
		longint a;
		longint num;
		longint den;
		longint q;
		a = n - k;
		num = a * a * p0 + 2 * k * a * p1 + k * k * p2;
		den = n * n;
		num = 2 * num + den;
		den = 2 * den;
		if (num >= 0)
			q = num / den;
		else
			q = -((-num + den - 1) / den);
		return q[15:0];
	endfunction

	// Queue every point of the curve that one request yields
	task automatic predict_curve(input qbez_pkg::in_item_t req);
		int n;
		qbez_pkg::out_item_t pt;
		n = req.segments;
		if (n == 0)
			n = 1;
		for (int k = 0; k <= n; k++) begin
			pt.point_x = curve_coord(req.start_x, req.ctrl_x, req.end_x, n, k);
			pt.point_y = curve_coord(req.start_y, req.ctrl_y, req.end_y, n, k);
			pt.last_point = (k == n);
			expected_points = {expected_points, pt};
		end
	endtask

	// Offer one request, hold it until accepted
	task automatic send_request(input qbez_pkg::in_item_t req);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_curve(req);
		request_count++;
	endtask

	// Drop the input once no further request follows
	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	function automatic qbez_pkg::in_item_t random_request(input int max_seg);
		qbez_pkg::in_item_t req;
		req.start_x = 16'($urandom);
		req.start_y = 16'($urandom);
		req.ctrl_x = 16'($urandom);
		req.ctrl_y = 16'($urandom);
		req.end_x = 16'($urandom);
		req.end_y = 16'($urandom);
		req.segments = 6'($urandom_range(0, max_seg));
		return req;
	endfunction

	task automatic wait_drained();
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of every coordinate and of the segment count, then random requests
	task automatic test_directed();
		qbez_pkg::in_item_t req;
		logic signed [15:0] ext [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		req = '0;
		send_request(req);
		req.segments = 6'd63;
		send_request(req);
		for (int i = 0; i < 4; i++) begin
			req.start_x = ext[i];
			req.start_y = ext[3 - i];
			req.ctrl_x = ext[(i + 1) % 4];
			req.ctrl_y = ext[(i + 2) % 4];
			req.end_x = ext[(i + 3) % 4];
			req.end_y = ext[(i + 2) % 4];
			req.segments = (i % 2) ? 6'd63 : 6'd1;
			send_request(req);
		end
		// full swing from min to max, and a vertical line
		req = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 6'd0};
		send_request(req);
		req.segments = 6'd2;
		send_request(req);
		req = '{16'sd5, -16'sd100, 16'sd5, 16'sd3, 16'sd5, 16'sd101, 6'd7};
		send_request(req);
		req = '{-16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 6'd4};
		send_request(req);
		for (int i = 0; i < 6; i++)
			send_request(random_request(63));
	endtask

	// Mostly short curves with random content, a few long ones
	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_request(random_request(($urandom_range(0, 9) == 0) ? 63 : 8));
	endtask

	// Hold the output long enough that the input must stall
	task automatic test_back_pressure();
		hold_output = 1'b1;
		no_gaps = 1'b1;
		test_random(12);
		no_gaps = 1'b0;
	endtask

	// Pause the sender until the curve drains, then resume
	task automatic test_drain_pause();
		test_random(5);
		stop_sending();
		wait_drained();
		repeat (LATENCY) @(posedge clk);
		test_random(5);
	endtask

	// Random output stall per result, with stall-free stretches
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (request_count > 80 && request_count < 110)
				wait_n = 0;
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (wait_n > 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Compare each accepted point with the oldest prediction
	always @(posedge clk) begin
		qbez_pkg::out_item_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			point_count++;
			if (expected_points.size() == 0) begin
				$error("unexpected point x=%0d y=%0d", out_data.point_x, out_data.point_y);
				fail_count++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (out_data.point_x !== exp_pt.point_x) begin
					$error("point_x expected %0d actual %0d", exp_pt.point_x, out_data.point_x);
					fail_count++;
				end
				if (out_data.point_y !== exp_pt.point_y) begin
					$error("point_y expected %0d actual %0d", exp_pt.point_y, out_data.point_y);
					fail_count++;
				end
				if (out_data.last_point !== exp_pt.last_point) begin
					$error("last_point expected %0b actual %0b", exp_pt.last_point,
						out_data.last_point);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		request_count = 0;
		point_count = 0;
		idle_cycles = 0;
		hold_output = 1'b0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_random(172);
		test_drain_pause();
		stop_sending();
		wait_drained();
		repeat (LATENCY) @(posedge clk);
		$display("Covered %0d curve requests and %0d points, incl. extremes and stalls.",
			request_count, point_count);
		if (fail_count == 0 && expected_points.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/qbez_pkg.sv
sv/qbez_div.sv
sv/quadratic_bezier_point_generator_unit.sv
tb/tb_quadratic_bezier_point_generator_unit.sv
